// ===== rtl/core/pkcb_pkg.sv =====
package pkcb_pkg;

    // default sizing
    localparam int KEY_COUNT_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    // fixed field widths
    localparam int KEY_IDX_W = 4;
    localparam int OUTCOME_W = 3;
    localparam int LIMIT_W   = 8;
    localparam int WAIT_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // register reset values and failure count ceiling
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(2);
    localparam logic [WAIT_W-1:0]  WAIT_RST  = WAIT_W'(10);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS    = 1'b1;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CALL = 1'b1;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_TICK            = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_RAN_OK          = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FAILED_FALLBACK = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FAILED_RAISED   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_REJECT_FALLBACK = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_REJECT_RAISED   = 3'd5;

    // breaker mode per key
    typedef enum logic [1:0] {
        MODE_PASSING = 2'd0,
        MODE_TRIPPED = 2'd1,
        MODE_TRIAL   = 2'd2
    } t_mode;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/core/per_key_circuit_breaker_unit.sv =====
// Per-key circuit breaker. After reset the block sweeps its key store clear, one key
// per cycle, so busy stays high until the last key is cleared, and only then is the
// first transaction taken. An item is accepted when start is high and busy is low;
// the key's entry is read from the store at that edge, and in the next cycle the
// entry is updated and written back while busy is high. The result appears on
// o_outcome and o_tripped_now with o_valid high for exactly one cycle, the cycle after
// busy was high; it cannot be held off, so it must be taken then. That same cycle a
// new transaction may already be started. Configuration writes are always taken.
module per_key_circuit_breaker_unit
    import pkcb_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [KEY_IDX_W-1:0]  i_key_index,
    input  logic                  i_call_fails,
    input  logic                  i_has_fallback,
    output logic                  o_valid,
    output logic [OUTCOME_W-1:0]  o_outcome,
    output logic                  o_tripped_now,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    t_cmd             w_cmd;
    logic [KEY_W-1:0] w_clr_addr;

    assign o_cfg_ready = 1'b1;

    // controller
    pkcb_ctrl #(
        .KEY_COUNT (KEY_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .o_cmd      (w_cmd),
        .o_clr_addr (w_clr_addr)
    );

    // datapath
    pkcb_dpath #(
        .KEY_COUNT (KEY_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_clr_addr     (w_clr_addr),
        .i_op           (i_op),
        .i_key_index    (i_key_index),
        .i_call_fails   (i_call_fails),
        .i_has_fallback (i_has_fallback),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_outcome      (o_outcome),
        .o_tripped_now  (o_tripped_now)
    );

    // a result always follows an update cycle
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_cmd.exec))
        else $error("result strobe without an update cycle");

    // an accepted transaction keeps the block busy for its update cycle
    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> (busy && w_cmd.exec))
        else $error("update cycle missing after capture");

    // a trip only comes with a failed call
    a_trip_on_failure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tripped_now) |->
            (o_outcome == OUT_FAILED_FALLBACK || o_outcome == OUT_FAILED_RAISED))
        else $error("trip reported without a failed call");

endmodule

// ===== rtl/core/pkcb_ctrl.sv =====
module pkcb_ctrl
    import pkcb_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    output t_cmd                     o_cmd,
    output logic [((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1)-1:0] o_clr_addr
);

    function automatic int KEY_W_CALC();
        return (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    endfunction

    localparam int KEY_W = KEY_W_CALC();
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEY_COUNT - 1);

    t_state r_state, n_state;
    logic [KEY_W-1:0] r_clr_addr, n_clr_addr;

    // state and sweep address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_cmd      = '0;
        busy       = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (r_clr_addr == LAST_KEY) begin
                    n_state    = ST_IDLE;
                    n_clr_addr = '0;
                end else begin
                    n_clr_addr = r_clr_addr + KEY_W'(1);
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_clr_addr = r_clr_addr;

endmodule

// ===== rtl/core/pkcb_dpath.sv =====
module pkcb_dpath
    import pkcb_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1)-1:0] i_clr_addr,
    input  logic                     i_op,
    input  logic [KEY_IDX_W-1:0]     i_key_index,
    input  logic                     i_call_fails,
    input  logic                     i_has_fallback,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data,
    output logic                     o_valid,
    output logic [OUTCOME_W-1:0]     o_outcome,
    output logic                     o_tripped_now
);

    function automatic int KEY_W_CALC();
        return (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    endfunction

    localparam int KEY_W   = KEY_W_CALC();
    localparam int ENTRY_W = 2 + COUNT_W + TIME_BITS;
    localparam int CMP_W   = (TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W;
    localparam int IDX_N   = 2 ** KEY_IDX_W;

    // per-key breaker store: {mode, count, trip time}
    logic [ENTRY_W-1:0] r_mem [KEY_COUNT];

    logic [LIMIT_W-1:0]   r_limit;
    logic [WAIT_W-1:0]    r_wait;
    logic [TIME_BITS-1:0] r_time, n_time;

    logic                 r_op, r_fails, r_fallback;
    logic [KEY_W-1:0]     r_key;
    logic [ENTRY_W-1:0]   r_rd;

    logic                 r_valid;
    logic [OUTCOME_W-1:0] r_outcome, n_outcome;
    logic                 r_tripped, n_tripped;

    logic [KEY_W-1:0]     w_key_map [IDX_N];
    logic                 w_we;
    logic [KEY_W-1:0]     w_waddr;
    logic [ENTRY_W-1:0]   w_wdata;

    t_mode                w_mode, w_mode_new;
    logic [COUNT_W-1:0]   w_cnt, w_cnt_new, w_cnt_inc;
    logic [TIME_BITS-1:0] w_tt, w_tt_new, w_elapsed;
    logic                 w_wait_open;
    logic                 w_upd;

    // key index folding onto the store depth
    for (genvar v = 0; v < IDX_N; v++) begin : g_key_map
        assign w_key_map[v] = KEY_W'(v % KEY_COUNT);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
            r_wait  <= WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FAILURE_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_WAIT_TICKS:    r_wait  <= i_cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // shared time counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else begin
            r_time <= n_time;
        end
    end

    // capture the transaction and read its key entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_op;
            r_fails    <= i_call_fails;
            r_fallback <= i_has_fallback;
            r_key      <= w_key_map[i_key_index];
            r_rd       <= r_mem[w_key_map[i_key_index]];
        end
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // unpack the entry read
    assign w_mode    = t_mode'(r_rd[ENTRY_W-1 -: 2]);
    assign w_cnt     = r_rd[TIME_BITS +: COUNT_W];
    assign w_tt      = r_rd[TIME_BITS-1:0];
    assign w_elapsed = r_time - w_tt;
    assign w_wait_open = CMP_W'(w_elapsed) >= CMP_W'(r_wait);
    assign w_cnt_inc = (w_cnt == COUNT_MAX) ? w_cnt : w_cnt + COUNT_W'(1);

    // breaker update
    always_comb begin
        n_time     = r_time;
        n_outcome  = OUT_TICK;
        n_tripped  = 1'b0;
        w_upd      = 1'b0;
        w_mode_new = w_mode;
        w_cnt_new  = w_cnt;
        w_tt_new   = w_tt;
        if (i_cmd.exec) begin
            if (r_op == OP_TICK) begin
                n_time = r_time + TIME_BITS'(1);
            end else if (w_mode == MODE_TRIPPED && !w_wait_open) begin
                n_outcome = r_fallback ? OUT_REJECT_FALLBACK : OUT_REJECT_RAISED;
            end else begin
                w_upd = 1'b1;
                // wait elapsed: tripped key goes to trial
                if (w_mode == MODE_TRIPPED) begin
                    w_mode_new = MODE_TRIAL;
                    w_tt_new   = r_time;
                end
                if (!r_fails) begin
                    if (w_mode_new == MODE_TRIAL) begin
                        w_mode_new = MODE_PASSING;
                        w_cnt_new  = '0;
                    end
                    n_outcome = OUT_RAN_OK;
                end else begin
                    w_cnt_new = w_cnt_inc;
                    if (w_cnt_inc > COUNT_W'(r_limit)) begin
                        w_mode_new = MODE_TRIPPED;
                        w_tt_new   = r_time;
                        n_tripped  = 1'b1;
                    end
                    n_outcome = r_fallback ? OUT_FAILED_FALLBACK : OUT_FAILED_RAISED;
                end
            end
        end
    end

    // write select: clearing sweep or call update
    assign w_we    = i_cmd.clear || w_upd;
    assign w_waddr = i_cmd.clear ? i_clr_addr : r_key;
    assign w_wdata = i_cmd.clear ? ENTRY_W'(0) : {w_mode_new, w_cnt_new, w_tt_new};

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_outcome <= n_outcome;
            r_tripped <= n_tripped;
        end
    end

    assign o_valid       = r_valid;
    assign o_outcome     = r_outcome;
    assign o_tripped_now = r_tripped;

endmodule
